/* rtl/grg_pkg.sv */
// grg_pkg: shared types, sizes and helpers of the gap run grouper
// used by grg_ctrl, grg_datapath, gap_run_grouper and grg_checker
// no dependencies
package grg_pkg;

   localparam int HOLD_DEPTH = 16;
   localparam int MIN_CAP    = (HOLD_DEPTH < 16) ? HOLD_DEPTH : 16;
   localparam int CNT_W      = $clog2(HOLD_DEPTH + 1);
   localparam int IDX_W      = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
   localparam int OFF_W      = 64;
   localparam int GAP_W      = 32;
   localparam int MIN_W      = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;

   localparam logic [MIN_W-1:0] MIN_RESET = MIN_W'(2);

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_GAP  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SIZE = CSR_IDX_W'(1);

   typedef struct packed {
      logic signed [OFF_W-1:0] rec_offset;
      logic signed [OFF_W-1:0] rec_key;
      logic                    final_record;
   } req_word_type;

   typedef struct packed {
      logic signed [OFF_W-1:0] out_offset;
      logic signed [OFF_W-1:0] out_key;
      logic                    group_start;
      logic                    last_of_run;
   } rsp_word_type;

   typedef struct packed {
      logic             capture;
      logic             update_prev;
      logic [IDX_W-1:0] rd_addr;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic             load;
      logic             load_held;
      logic             gs;
      logic             last;
   } dp_cmd_type;

   typedef struct packed {
      logic             near;
      logic             fin;
      logic [CNT_W-1:0] min_eff;
      logic             out_free;
   } dp_stat_type;

   // minimum run size with zero read as one and large values clamped
   function automatic logic [CNT_W-1:0] eff_min(input logic [MIN_W-1:0] raw);
      logic [CNT_W-1:0] m;
      if (raw == '0) begin
         m = CNT_W'(1);
      end else if (32'(raw) > MIN_CAP) begin
         m = CNT_W'(MIN_CAP);
      end else begin
         m = CNT_W'(raw);
      end
      return m;
   endfunction

endpackage

/* rtl/grg_datapath.sv */
// grg_datapath: config registers, current word, gap compare, hold memory
// and the output register of the gap run grouper
// depends on grg_pkg
module grg_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  grg_pkg::req_word_type          req_word,
   output grg_pkg::rsp_word_type          rsp_word,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic                           csr_we,
   input  logic [grg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [grg_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  grg_pkg::dp_cmd_type            cmd,
   output grg_pkg::dp_stat_type           stat
);
   import grg_pkg::*;

   typedef struct packed {
      logic signed [OFF_W-1:0] off;
      logic signed [OFF_W-1:0] key;
   } held_entry_type;

   logic [GAP_W-1:0]        max_gap_ff;
   logic [MIN_W-1:0]        min_raw_ff;
   req_word_type            cur_ff;
   logic signed [OFF_W-1:0] prev_ff;
   held_entry_type          held_mem_ff [HOLD_DEPTH];
   held_entry_type          rd_data_ff;
   logic                    rsp_valid_ff;
   rsp_word_type            rsp_word_ff;
   rsp_word_type            rsp_word_in;
   logic [OFF_W-1:0]        diff;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_gap_ff <= '0;
         min_raw_ff <= MIN_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_GAP:  max_gap_ff <= csr_wdata[GAP_W-1:0];
            CSR_MIN_SIZE: min_raw_ff <= csr_wdata[MIN_W-1:0];
         endcase
      end
   end

   // current word and previous offset
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cur_ff <= req_word;
      end
      if (cmd.update_prev) begin
         prev_ff <= cur_ff.rec_offset;
      end
   end

   // gap test, difference is exact whenever the offset moved up
   assign diff = OFF_W'(cur_ff.rec_offset) - OFF_W'(prev_ff);

   always_comb begin
      stat.near     = (cur_ff.rec_offset <= prev_ff) ||
                      (diff <= {{(OFF_W-GAP_W){1'b0}}, max_gap_ff});
      stat.fin      = cur_ff.final_record;
      stat.min_eff  = eff_min(min_raw_ff);
      stat.out_free = !rsp_valid_ff || rsp_ready;
   end

   // hold memory
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         held_mem_ff[cmd.wr_addr] <= '{off: cur_ff.rec_offset, key: cur_ff.rec_key};
      end
      rd_data_ff <= held_mem_ff[cmd.rd_addr];
   end

   // output register
   always_comb begin
      if (cmd.load_held) begin
         rsp_word_in.out_offset = rd_data_ff.off;
         rsp_word_in.out_key    = rd_data_ff.key;
      end else begin
         rsp_word_in.out_offset = cur_ff.rec_offset;
         rsp_word_in.out_key    = cur_ff.rec_key;
      end
      rsp_word_in.group_start = cmd.gs;
      rsp_word_in.last_of_run = cmd.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.load) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

/* rtl/grg_ctrl.sv */
// grg_ctrl: run state and sequencing of the gap run grouper
// drives grg_datapath through dp_cmd_type, reads dp_stat_type
// depends on grg_pkg
module grg_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  grg_pkg::dp_stat_type  stat,
   output grg_pkg::dp_cmd_type   cmd
);
   import grg_pkg::*;

   typedef enum logic [1:0] {
      IDLE,
      DECIDE,
      HELD,
      CUR
   } state_type;

   typedef struct packed {
      logic             group;
      logic             emit_cur;
      logic             cur_gs;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic [IDX_W-1:0] last_idx;
   } plan_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             streaming_ff, streaming_in;
   logic             have_prev_ff, have_prev_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   plan_type         plan_ff, plan_in;

   plan_type         plan_c;
   logic             joins;
   logic             reach;
   logic             m_one;
   logic             c1, c2, c3, c4;
   logic             held_go;
   logic [CNT_W:0]   cnt_inc;

   // decision for the current word
   always_comb begin
      joins   = have_prev_ff && stat.near;
      cnt_inc = {1'b0, count_ff} + (CNT_W+1)'(1);
      reach   = cnt_inc >= {1'b0, stat.min_eff};
      m_one   = stat.min_eff == CNT_W'(1);
      c1      = joins && streaming_ff;
      c2      = joins && !streaming_ff && reach;
      c3      = joins && !streaming_ff && !reach;
      c4      = !joins;
      held_go = !(c3 && !stat.fin) && (count_ff != '0);

      plan_c.group    = c2 || (c4 && (count_ff >= stat.min_eff));
      plan_c.emit_cur = c1 || c2 || (c3 && stat.fin) || (c4 && (m_one || stat.fin));
      plan_c.cur_gs   = c1 ? 1'b0 : (c2 ? (count_ff == '0) : 1'b1);
      plan_c.wr_en    = !stat.fin && (c3 || (c4 && !m_one));
      plan_c.wr_addr  = c3 ? count_ff[IDX_W-1:0] : '0;
      plan_c.last_idx = IDX_W'(count_ff - CNT_W'(1));
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      streaming_in = streaming_ff;
      have_prev_in = have_prev_ff;
      idx_in       = idx_ff;
      plan_in      = plan_ff;
      cmd          = '0;
      req_ready    = 1'b0;

      unique case (state_ff)
         IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = DECIDE;
            end
         end
         DECIDE: begin
            cmd.update_prev = 1'b1;
            cmd.rd_addr     = '0;
            plan_in         = plan_c;
            idx_in          = '0;
            have_prev_in    = !stat.fin;
            streaming_in    = (c1 || c2 || (c4 && m_one)) && !stat.fin;
            if (plan_c.wr_en) begin
               count_in = c3 ? CNT_W'(cnt_inc) : CNT_W'(1);
            end else begin
               count_in = '0;
            end
            if (held_go) begin
               state_in = HELD;
            end else if (plan_c.emit_cur) begin
               if (stat.out_free) begin
                  cmd.load = 1'b1;
                  cmd.gs   = plan_c.cur_gs;
                  cmd.last = 1'b1;
                  state_in = IDLE;
               end else begin
                  state_in = CUR;
               end
            end else begin
               cmd.wr_en   = plan_c.wr_en;
               cmd.wr_addr = plan_c.wr_addr;
               state_in    = IDLE;
            end
         end
         HELD: begin
            cmd.rd_addr = idx_ff;
            if (stat.out_free) begin
               cmd.load      = 1'b1;
               cmd.load_held = 1'b1;
               cmd.gs        = plan_ff.group ? (idx_ff == '0) : 1'b1;
               cmd.last      = !plan_ff.emit_cur && (idx_ff == plan_ff.last_idx);
               if (idx_ff == plan_ff.last_idx) begin
                  if (plan_ff.emit_cur) begin
                     state_in = CUR;
                  end else begin
                     cmd.wr_en   = plan_ff.wr_en;
                     cmd.wr_addr = plan_ff.wr_addr;
                     state_in    = IDLE;
                  end
               end else begin
                  idx_in      = idx_ff + IDX_W'(1);
                  cmd.rd_addr = idx_in;
               end
            end
         end
         CUR: begin
            if (stat.out_free) begin
               cmd.load = 1'b1;
               cmd.gs   = plan_ff.cur_gs;
               cmd.last = 1'b1;
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         count_ff     <= '0;
         streaming_ff <= 1'b0;
         have_prev_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         streaming_ff <= streaming_in;
         have_prev_ff <= have_prev_in;
         idx_ff       <= idx_in;
      end
      plan_ff <= plan_in;
   end

endmodule

/* rtl/gap_run_grouper.sv */
// gap_run_grouper: top level, joins the controller and the datapath
// depends on grg_pkg, grg_ctrl, grg_datapath
//
// Groups a stream of (offset, key) words into runs of close offsets. A
// word that is held or gives one result is accepted and then decided; a
// word that releases held records sends them first, then its own record
// when that follows them, as held records leave the hold memory one per
// cycle while the output is free, through its single read port. A single
// registered output word sits on the result side; while it waits to be
// taken, a word with results to give stalls and holds off the next input
// word. The user must write the gap limit and the minimum run size only while
// the block is idle; the block itself does not enforce it. No clearing pass is needed after reset.
module gap_run_grouper (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  grg_pkg::req_word_type          req_word,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output grg_pkg::rsp_word_type          rsp_word,
   input  logic                           csr_we,
   input  logic [grg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [grg_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import grg_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   grg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   grg_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .rsp_word  (rsp_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

/* rtl/grg_checker.sv */
// grg_checker: port level checks of the gap run grouper, bound to the top
// depends on grg_pkg
module grg_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input grg_pkg::req_word_type req_word,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input grg_pkg::rsp_word_type rsp_word
);
   import grg_pkg::*;

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("result word dropped or changed while stalled");

   // stalled input word holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_word))
      else $error("input word dropped or changed while stalled");

   // one word at a time
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("new word taken before the previous one was decided");

   // output empty after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind gap_run_grouper grg_checker u_grg_checker (.*);

/* verif/gap_run_grouper_tb.sv */
// gap_run_grouper_tb: self-checking testbench for the gap run grouper
// predicts every result word in a small scoreboard class and drives random traffic
// depends on grg_pkg and gap_run_grouper
module gap_run_grouper_tb;
   import grg_pkg::*;

   localparam int LIMIT  = 1000000;
   localparam int SETTLE = 40;

   class grouping_scoreboard;
      logic [GAP_W-1:0] max_gap;
      logic [MIN_W-1:0] min_size;
      logic [63:0]      prev_off;
      bit               have_prev;
      int unsigned      run_count;
      bit               streaming;
      logic [63:0]      held_off [HOLD_DEPTH];
      logic [63:0]      held_key [HOLD_DEPTH];
      rsp_word_type     step_out [$];
      rsp_word_type     pending_records [$];
      int               errors;
      int               words_in;
      int               words_out;

      function new();
         max_gap   = '0;
         min_size  = MIN_RESET;
         prev_off  = '0;
         have_prev = 0;
         run_count = 0;
         streaming = 0;
         errors    = 0;
         words_in  = 0;
         words_out = 0;
      endfunction

      function int unsigned min_eff();
         int unsigned m;
         m = 32'(min_size);
         if (m == 0) begin
            m = 1;
         end
         if (m > 16) begin
            m = 16;
         end
         if (m > HOLD_DEPTH) begin
            m = HOLD_DEPTH;
         end
         return m;
      endfunction

      function void add(logic [63:0] off, logic [63:0] key, logic gs);
         rsp_word_type r;
         r.out_offset  = off;
         r.out_key     = key;
         r.group_start = gs;
         r.last_of_run = 1'b0;
         step_out = {step_out, r};
      endfunction

      function void flush_held(bit as_group);
         for (int i = 0; i < run_count && i < HOLD_DEPTH; i++) begin
            add(held_off[i], held_key[i], as_group ? (i == 0) : 1'b1);
         end
      endfunction

      function void hold_rec(logic [63:0] off, logic [63:0] key);
         if (run_count < HOLD_DEPTH) begin
            held_off[run_count] = off;
            held_key[run_count] = key;
            run_count++;
         end
      endfunction

      function void note_input(req_word_type w);
         logic [63:0] off;
         logic [63:0] key;
         bit          joins;
         int unsigned m;
         off = w.rec_offset;
         key = w.rec_key;
         m = min_eff();
         joins = 0;
         step_out.delete();
         words_in++;
         if (have_prev) begin
            if ($signed(off) <= $signed(prev_off)) begin
               joins = 1;
            end else begin
               joins = (off - prev_off) <= {32'd0, max_gap};
            end
         end
         if (joins) begin
            if (streaming) begin
               add(off, key, 1'b0);
            end else if (run_count + 1 >= m) begin
               flush_held(1'b1);
               add(off, key, run_count == 0);
               run_count = 0;
               streaming = 1;
            end else begin
               hold_rec(off, key);
            end
         end else begin
            if (have_prev) begin
               // closing run: group if long enough, else single-record groups
               if (!streaming) begin
                  flush_held(run_count >= m);
               end
               run_count = 0;
               streaming = 0;
            end
            if (m <= 1) begin
               add(off, key, 1'b1);
               streaming = 1;
            end else begin
               hold_rec(off, key);
            end
         end
         prev_off  = off;
         have_prev = 1;
         if (w.final_record) begin
            if (!streaming) begin
               flush_held(1'b0);
            end
            run_count = 0;
            streaming = 0;
            have_prev = 0;
         end
         if (step_out.size() > 0) begin
            step_out[step_out.size() - 1].last_of_run = 1'b1;
         end
         pending_records = {pending_records, step_out};
      endfunction

      function void check_result(rsp_word_type got);
         rsp_word_type exp_w;
         words_out++;
         if (pending_records.size() == 0) begin
            errors++;
            if (errors <= 10) begin
               $display("mismatch: unexpected word off=%h key=%h gs=%b last=%b",
                        got.out_offset, got.out_key, got.group_start, got.last_of_run);
            end
         end else begin
            exp_w = pending_records.pop_front();
            if (got.out_offset !== exp_w.out_offset || got.out_key !== exp_w.out_key ||
                got.group_start !== exp_w.group_start ||
                got.last_of_run !== exp_w.last_of_run) begin
               errors++;
               if (errors <= 10) begin
                  $display("mismatch: expected off=%h key=%h gs=%b last=%b",
                           exp_w.out_offset, exp_w.out_key, exp_w.group_start,
                           exp_w.last_of_run);
                  $display("          got      off=%h key=%h gs=%b last=%b",
                           got.out_offset, got.out_key, got.group_start, got.last_of_run);
               end
            end
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_word_type          req_word = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_word_type          rsp_word;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_MAX_GAP;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   grouping_scoreboard board = new();

   bit          steady = 0;
   bit          rx_long_hold = 0;
   int          rx_hold_left = 0;
   int          rx_pick;
   int          cycle_count = 0;
   int          settings_count = 0;
   logic [63:0] walk_off = '0;
   int          run_left = 0;

   gap_run_grouper dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // result side: check accepted words, then pick the next ready value
   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) begin
         board.check_result(rsp_word);
      end
      if (rx_long_hold) begin
         rx_long_hold = 1'b0;
         rx_hold_left = 400;
      end
      if (rx_hold_left > 0) begin
         rsp_ready <= 1'b0;
         rx_hold_left = rx_hold_left - 1;
      end else if (steady) begin
         rsp_ready <= 1'b1;
      end else begin
         rx_pick = $urandom_range(0, 99);
         if (rx_pick < 65) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b0;
            if (rx_pick < 90) begin
               rx_hold_left = $urandom_range(0, 2);
            end else if (rx_pick < 98) begin
               rx_hold_left = $urandom_range(3, 11);
            end else begin
               rx_hold_left = $urandom_range(19, 39);
            end
         end
      end
   end

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 60) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end else if (r < 98) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic req_word_type make_req(logic [63:0] off, logic [63:0] key, logic fin);
      req_word_type w;
      w.rec_offset   = off;
      w.rec_key      = key;
      w.final_record = fin;
      return w;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic send_word(input req_word_type w);
      int idle;
      req_word  <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      board.note_input(w);
      idle = idle_len();
      if (idle > 0) begin
         req_valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
   endtask

   task automatic wait_drained(input bit settle);
      req_valid <= 1'b0;
      while (board.pending_records.size() != 0) begin
         @(posedge clock);
      end
      if (settle) begin
         repeat (SETTLE) @(posedge clock);
      end
   endtask

   task automatic write_settings(input logic [31:0] gap, input logic [MIN_W-1:0] min_sz);
      wait_drained(1'b1);
      csr_we    <= 1'b1;
      csr_index <= CSR_MAX_GAP;
      csr_wdata <= gap;
      @(posedge clock);
      csr_index <= CSR_MIN_SIZE;
      csr_wdata <= {(CSR_DATA_W - MIN_W)'($urandom_range(0, 2 ** (CSR_DATA_W - MIN_W) - 1)),
                    min_sz};
      @(posedge clock);
      csr_we <= 1'b0;
      board.max_gap  = gap;
      board.min_size = min_sz;
      settings_count++;
   endtask

   // mostly well-formed runs around the gap limit, with some noise
   task automatic random_words(input int n);
      logic [63:0] off;
      logic [63:0] gap64;
      logic        fin;
      int          r;
      for (int k = 0; k < n; k++) begin
         r     = $urandom_range(0, 99);
         gap64 = {32'd0, board.max_gap};
         fin   = ($urandom_range(0, 29) == 0);
         if (r < 6) begin
            off = rand64();
            fin = 1'($urandom_range(0, 1));
         end else if (r < 10) begin
            off = walk_off - $urandom_range(0, 1000);
         end else if (run_left == 0) begin
            if ($urandom_range(0, 9) == 0) begin
               walk_off = rand64();
            end
            off = walk_off + gap64 + 64'd1;
            if ($urandom_range(0, 2) != 0) begin
               off = off + $urandom_range(0, 5000);
            end
            run_left = $urandom_range(0, board.min_eff() + 2);
         end else begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
               off = walk_off + gap64;
            end else if (r < 55) begin
               off = walk_off + $urandom_range(0, (board.max_gap < 16) ? board.max_gap : 16);
            end else begin
               off = walk_off + $urandom_range(board.max_gap, 0);
            end
            run_left--;
         end
         walk_off = off;
         if (fin) begin
            run_left = 0;
         end
         send_word(make_req(off, rand64(), fin));
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: equal offsets join, extremes of offset and key
      send_word(make_req(64'd0, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0));
      send_word(make_req(64'd0, 64'h8000_0000_0000_0000, 1'b0));
      send_word(make_req(64'd1, 64'd0, 1'b0));
      send_word(make_req(64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0));
      send_word(make_req(64'h7FFF_FFFF_FFFF_FFFF, 64'd1, 1'b1));

      // widest gap, short runs closed and flushed as single groups
      write_settings(32'hFFFF_FFFF, 5'd16);
      walk_off = -64'sd5;
      send_word(make_req(walk_off, rand64(), 1'b0));
      walk_off = walk_off + 64'h0000_0000_FFFF_FFFF;
      send_word(make_req(walk_off, rand64(), 1'b0));
      walk_off = walk_off + 64'h0000_0001_0000_0000;
      send_word(make_req(walk_off, rand64(), 1'b0));
      send_word(make_req(walk_off, rand64(), 1'b1));

      // zero minimum behaves as one: every word streams out
      write_settings(32'd0, 5'd0);
      send_word(make_req(64'd7, rand64(), 1'b0));
      send_word(make_req(64'd7, rand64(), 1'b0));
      send_word(make_req(64'd9, rand64(), 1'b1));

      // oversized minimum clamps to the hold depth: full group in one go
      write_settings(32'hFFFF_FFFF, 5'd31);
      for (int i = 1; i <= 16; i++) begin
         send_word(make_req(64'(i * 100), rand64(), i == 16));
      end

      write_settings(32'd0, 5'd1);
      random_words(10);
      rx_long_hold = 1'b1;
      random_words(45);

      write_settings(32'hFFFF_FFFF, 5'd16);
      random_words(55);

      steady = 1;
      write_settings(32'd10, 5'd3);
      random_words(55);
      steady = 0;

      write_settings(32'd1000, 5'd2);
      random_words(25);
      wait_drained(1'b0);
      random_words(30);

      write_settings(32'd0, 5'd0);
      random_words(50);

      steady = 1;
      write_settings(32'hFFFF_FFFF, 5'd31);
      random_words(55);
      steady = 0;

      write_settings($urandom_range(0, 50), MIN_W'($urandom_range(1, 8)));
      random_words(55);

      write_settings(32'h8000_0000, 5'd17);
      random_words(55);

      wait_drained(1'b1);
      $display("covered %0d input words and %0d result words over %0d register settings",
               board.words_in, board.words_out, settings_count);
      $display("mismatches found: %0d", board.errors);
      if (board.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
